[design/ft12_frame_detector_defines.svh]
// ----------------------------------------------------------------------------
// ft12 frame detector assertion macros
// Concurrent assertion wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef FT12_FRAME_DETECTOR_DEFINES_SVH
`define FT12_FRAME_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define FT12_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ft12 frame detector assertion failed");
// condition that must never be true outside reset
`define FT12_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("ft12 frame detector forbidden condition seen");
`else
`define FT12_ASSERT(label, prop)
`define FT12_ASSERT_NEVER(label, expr)
`endif

`endif

[design/ft12_pkg.sv]
// ----------------------------------------------------------------------------
// ft12 package
// Types and constants shared by the ft12 frame detector and its interfaces.
// ----------------------------------------------------------------------------
package ft12_pkg;

   // frame geometry
   localparam logic [8:0] FIXED_LEN = 9'd5;
   localparam logic [8:0] VAR_EXTRA = 9'd6;

   // register reset values
   localparam logic [7:0] FIXED_START_RESET = 8'h10;
   localparam logic [7:0] VAR_START_RESET   = 8'h68;
   localparam logic [7:0] END_CODE_RESET    = 8'h16;

   // register indexes
   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIXED_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VAR_START   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_CODE    = 2'd2;

   // parser mode
   typedef enum logic [2:0] {
      MODE_HUNT  = 3'b001,
      MODE_FIXED = 3'b010,
      MODE_VAR   = 3'b100
   } mode_type;

   // one result item
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       in_frame;
      logic [8:0] frame_position;
      logic       variable_kind;
      logic       frame_last;
      logic       frame_good;
      logic [8:0] frame_total_length;
   } rsp_type;

endpackage

[design/ft12_req_if.sv]
// ----------------------------------------------------------------------------
// ft12 byte input channel
// Valid/ready channel carrying one received serial byte per transfer.
// ----------------------------------------------------------------------------
interface ft12_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[design/ft12_rsp_if.sv]
// ----------------------------------------------------------------------------
// ft12 result channel
// Valid/ready channel carrying one classified byte per transfer.
// ----------------------------------------------------------------------------
interface ft12_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       in_frame;
   logic [8:0] frame_position;
   logic       variable_kind;
   logic       frame_last;
   logic       frame_good;
   logic [8:0] frame_total_length;

   modport source (
      output valid, output frame_byte, output in_frame, output frame_position,
      output variable_kind, output frame_last, output frame_good,
      output frame_total_length, input ready
   );
   modport sink (
      input valid, input frame_byte, input in_frame, input frame_position,
      input variable_kind, input frame_last, input frame_good,
      input frame_total_length, output ready
   );
endinterface

[design/ft12_csr_if.sv]
// ----------------------------------------------------------------------------
// ft12 register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ft12_csr_if
   import ft12_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [7:0]            wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

[design/ft12_frame_detector.sv]
// ----------------------------------------------------------------------------
// ft12 frame detector
// Hunts for fixed and variable ft1.2 frames in a byte stream and tags bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  takes one received byte per transfer.
//   rsp_bus  returns one result per byte: the byte, its offset in the
//            candidate frame, the frame kind, last/good flags and the total
//            frame length once known.
//   csr_bus  writes the fixed start, variable start and end codes; it is always ready;
//            users must write it only while no byte is in flight (not enforced).
// Timing:
//   Each byte is classified in the cycle it is accepted and its result sits
//   in the output register in the next cycle. A byte is accepted every cycle
//   unless the result channel stalls, set by the single parse state update
//   per byte.
// Reset:
//   Synchronous, active high. Codes return to 0x10, 0x68 and 0x16, the
//   parser returns to hunting and the output register is emptied.
// Stall:
//   While a result waits and rsp_bus.ready is low, req_bus.ready drops; the
//   byte already in the output register is held unchanged.
// ----------------------------------------------------------------------------
`include "ft12_frame_detector_defines.svh"

module ft12_frame_detector
   import ft12_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ft12_req_if.sink   req_bus,
   ft12_rsp_if.source rsp_bus,
   ft12_csr_if.sink   csr_bus
);

   // configuration registers
   logic [7:0] fixed_start_ff;
   logic [7:0] var_start_ff;
   logic [7:0] end_code_ff;

   // parse state
   mode_type   mode_ff, mode_in;
   logic [8:0] offset_ff, offset_in;
   logic [7:0] length_ff, length_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic       req_xfer;
   logic       rsp_xfer;
   logic       csr_xfer;
   logic [7:0] len_eff;
   logic [8:0] var_total;
   logic [7:0] b;

   // handshakes
   assign rsp_xfer        = rsp_valid_ff && rsp_bus.ready;
   assign req_bus.ready   = !rsp_valid_ff || rsp_bus.ready;
   assign req_xfer        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;
   assign csr_xfer        = csr_bus.valid;
   assign b               = req_bus.rx_byte;

   // length seen at offset one is used in the same byte
   assign len_eff   = (offset_ff == 9'd1) ? b : length_ff;
   assign var_total = {1'b0, len_eff} + VAR_EXTRA;

   // per-byte classification and next state
   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      rsp_in    = '0;
      rsp_in.frame_byte = b;
      unique case (mode_ff)
         MODE_FIXED: begin
            rsp_in.in_frame           = 1'b1;
            rsp_in.frame_position     = offset_ff;
            rsp_in.frame_total_length = FIXED_LEN;
            if (offset_ff >= FIXED_LEN - 9'd1) begin
               rsp_in.frame_last = 1'b1;
               rsp_in.frame_good = (b == end_code_ff);
               mode_in   = MODE_HUNT;
               offset_in = '0;
            end else begin
               offset_in = offset_ff + 9'd1;
            end
         end
         MODE_VAR: begin
            rsp_in.in_frame           = 1'b1;
            rsp_in.variable_kind      = 1'b1;
            rsp_in.frame_position     = offset_ff;
            rsp_in.frame_total_length = var_total;
            length_in = len_eff;
            if (offset_ff >= var_total - 9'd1) begin
               rsp_in.frame_last = 1'b1;
               rsp_in.frame_good = (b == end_code_ff);
               mode_in   = MODE_HUNT;
               offset_in = '0;
            end else begin
               offset_in = offset_ff + 9'd1;
            end
         end
         default: begin
            mode_in   = MODE_HUNT;
            offset_in = '0;
            if (b == fixed_start_ff) begin
               rsp_in.in_frame           = 1'b1;
               rsp_in.frame_total_length = FIXED_LEN;
               mode_in   = MODE_FIXED;
               offset_in = 9'd1;
            end else if (b == var_start_ff) begin
               rsp_in.in_frame      = 1'b1;
               rsp_in.variable_kind = 1'b1;
               mode_in   = MODE_VAR;
               offset_in = 9'd1;
               length_in = '0;
            end
         end
      endcase
   end

   // output valid tracking
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HUNT;
         offset_ff      <= '0;
         length_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         fixed_start_ff <= FIXED_START_RESET;
         var_start_ff   <= VAR_START_RESET;
         end_code_ff    <= END_CODE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            mode_ff   <= mode_in;
            offset_ff <= offset_in;
            length_ff <= length_in;
         end
         if (csr_xfer) begin
            unique case (csr_bus.addr)
               CSR_FIXED_START: fixed_start_ff <= csr_bus.wdata;
               CSR_VAR_START:   var_start_ff   <= csr_bus.wdata;
               CSR_END_CODE:    end_code_ff    <= csr_bus.wdata;
               default: ;
            endcase
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   // result channel drive
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.frame_byte         = rsp_ff.frame_byte;
   assign rsp_bus.in_frame           = rsp_ff.in_frame;
   assign rsp_bus.frame_position     = rsp_ff.frame_position;
   assign rsp_bus.variable_kind      = rsp_ff.variable_kind;
   assign rsp_bus.frame_last         = rsp_ff.frame_last;
   assign rsp_bus.frame_good         = rsp_ff.frame_good;
   assign rsp_bus.frame_total_length = rsp_ff.frame_total_length;

   // checks
   `FT12_ASSERT_NEVER(a_good_only_on_last,
      rsp_valid_ff && rsp_ff.frame_good && !rsp_ff.frame_last)
   `FT12_ASSERT(a_last_returns_to_hunt,
      (req_xfer && rsp_in.frame_last) |=> (mode_ff == MODE_HUNT))
   `FT12_ASSERT_NEVER(a_frame_offset_nonzero,
      (mode_ff != MODE_HUNT) && (offset_ff == 9'd0))
   `FT12_ASSERT(a_outside_frame_clean,
      (rsp_valid_ff && !rsp_ff.in_frame) |->
         (rsp_ff.frame_position == 9'd0 && rsp_ff.frame_total_length == 9'd0))

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// ft12 frame detector testbench
// Feeds byte streams built mostly from well-formed fixed and variable frames
// with random content, mixed with noise, cut-off frames and bad end bytes.
// A frame tracker class predicts the tag of every accepted byte and checks
// each result transfer against it. Code registers change between phases.
// ----------------------------------------------------------------------------
module testbench
   import ft12_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // index with no register behind it
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   localparam int PHASE_BYTES = 170;

   // predicts the tag of each byte and holds the tags still owed
   class frame_tracker;
      logic [7:0] fixed_start;
      logic [7:0] var_start;
      logic [7:0] end_code;
      mode_type   mode;
      logic [8:0] offset;
      logic [7:0] length;
      rsp_type    owed_tags[$];
      int         errors;
      int         checked;
      int         good_frames;
      int         bad_frames;
      int         longest;

      function new();
         fixed_start = FIXED_START_RESET;
         var_start   = VAR_START_RESET;
         end_code    = END_CODE_RESET;
         mode        = MODE_HUNT;
         offset      = '0;
         length      = '0;
         errors      = 0;
         checked     = 0;
         good_frames = 0;
         bad_frames  = 0;
         longest     = 0;
      endfunction

      function void write_code(logic [CSR_ADDR_W-1:0] index, logic [7:0] value);
         case (index)
            CSR_FIXED_START: fixed_start = value;
            CSR_VAR_START:   var_start = value;
            CSR_END_CODE:    end_code = value;
            default: ;
         endcase
      endfunction

      // work out the tag of one accepted byte and advance the parser
      function void note_byte(logic [7:0] b);
         rsp_type tag;
         tag = '0;
         tag.frame_byte = b;
         case (mode)
            MODE_FIXED: begin
               tag.in_frame = 1'b1;
               tag.frame_position = offset;
               tag.frame_total_length = FIXED_LEN;
               if (offset >= FIXED_LEN - 9'd1) begin
                  tag.frame_last = 1'b1;
                  tag.frame_good = (b == end_code);
                  mode = MODE_HUNT;
                  offset = '0;
               end else begin
                  offset = offset + 9'd1;
               end
            end
            MODE_VAR: begin
               tag.in_frame = 1'b1;
               tag.variable_kind = 1'b1;
               tag.frame_position = offset;
               if (offset == 9'd1) begin
                  length = b;
                  if (int'(b) > longest) longest = int'(b);
               end
               tag.frame_total_length = {1'b0, length} + VAR_EXTRA;
               if (offset >= tag.frame_total_length - 9'd1) begin
                  tag.frame_last = 1'b1;
                  tag.frame_good = (b == end_code);
                  mode = MODE_HUNT;
                  offset = '0;
               end else begin
                  offset = offset + 9'd1;
               end
            end
            default: begin
               // fixed start wins when both codes are equal
               mode = MODE_HUNT;
               offset = '0;
               if (b == fixed_start) begin
                  tag.in_frame = 1'b1;
                  tag.frame_total_length = FIXED_LEN;
                  mode = MODE_FIXED;
                  offset = 9'd1;
               end else if (b == var_start) begin
                  tag.in_frame = 1'b1;
                  tag.variable_kind = 1'b1;
                  mode = MODE_VAR;
                  offset = 9'd1;
                  length = '0;
               end
            end
         endcase
         if (tag.frame_last) begin
            if (tag.frame_good) good_frames++;
            else bad_frames++;
         end
         owed_tags.push_back(tag);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      // compare one result transfer with the oldest owed tag
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed_tags.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual byte %0d",
                     $time, got.frame_byte);
            return;
         end
         want = owed_tags.pop_front();
         checked++;
         compare_field("frame_byte", want.frame_byte, got.frame_byte);
         compare_field("in_frame", want.in_frame, got.in_frame);
         compare_field("frame_position", want.frame_position, got.frame_position);
         compare_field("variable_kind", want.variable_kind, got.variable_kind);
         compare_field("frame_last", want.frame_last, got.frame_last);
         compare_field("frame_good", want.frame_good, got.frame_good);
         compare_field("frame_total_length", want.frame_total_length,
                       got.frame_total_length);
      endfunction

      function int pending();
         return owed_tags.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ft12_req_if req_bus();
   ft12_rsp_if rsp_bus();
   ft12_csr_if csr_bus();

   ft12_frame_detector uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_tracker tracker;
   int  bytes_sent;
   int  code_settings;
   bit  req_calm;
   bit  rsp_calm;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   // wait before the next transfer, none while a calm stretch lasts
   function automatic int draw_wait(bit calm);
      if (calm) return 0;
      return $urandom_range(0, 14);
   endfunction

   // one byte transfer on the input channel
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_byte(b);
      bytes_sent++;
   endtask

   // frame body byte, now and then one of the codes
   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 11))
         0: return tracker.fixed_start;
         1: return tracker.var_start;
         2: return tracker.end_code;
         default: return 8'($urandom);
      endcase
   endfunction

   // closing byte, right or deliberately wrong
   function automatic logic [7:0] close_byte(bit wrong);
      if (wrong) return tracker.end_code ^ 8'($urandom_range(1, 255));
      return tracker.end_code;
   endfunction

   task automatic send_fixed_frame(input bit wrong);
      send_byte(tracker.fixed_start);
      repeat (3) send_byte(body_byte());
      send_byte(close_byte(wrong));
   endtask

   task automatic send_var_frame(input logic [7:0] len, input bit wrong);
      send_byte(tracker.var_start);
      send_byte(len);
      repeat (int'(len) + 3) send_byte(body_byte());
      send_byte(close_byte(wrong));
   endtask

   function automatic logic [7:0] draw_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) return 8'hff;
      if (pick < 6) return 8'($urandom);
      return 8'($urandom_range(0, 12));
   endfunction

   // mostly whole frames, some noise and cut-off frames
   task automatic random_traffic(input int count);
      int stop;
      int pick;
      stop = bytes_sent + count;
      while (bytes_sent < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_fixed_frame($urandom_range(0, 4) == 0);
         end else if (pick < 75) begin
            send_var_frame(draw_length(), $urandom_range(0, 4) == 0);
         end else if (pick < 85) begin
            // cut-off frame, the following bytes get absorbed into it
            send_byte($urandom_range(0, 1) ? tracker.fixed_start : tracker.var_start);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 15)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end
      end
   endtask

   // let every owed tag come back and the pipeline empty
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write all codes plus the spare index, valid held across the transfers
   task automatic program_codes(input logic [7:0] fs, input logic [7:0] vs,
                                input logic [7:0] ec);
      logic [CSR_ADDR_W-1:0] index [4];
      logic [7:0]            value [4];
      index = '{CSR_SPARE, CSR_FIXED_START, CSR_VAR_START, CSR_END_CODE};
      value = '{8'($urandom), fs, vs, ec};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.addr <= index[i];
         csr_bus.wdata <= value[i];
         do @(posedge clock); while (!csr_bus.ready);
         tracker.write_code(index[i], value[i]);
      end
      csr_bus.valid <= 1'b0;
      code_settings++;
   endtask

   // directed bytes with the reset codes
   task automatic directed_frames();
      // good fixed frame, variable start inside it
      send_byte(FIXED_START_RESET);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(VAR_START_RESET);
      send_byte(END_CODE_RESET);
      // variable frame of length zero, codes inside
      send_byte(VAR_START_RESET);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(VAR_START_RESET);
      send_byte(FIXED_START_RESET);
      send_byte(END_CODE_RESET);
      // fixed frame with end codes early and a bad last byte
      send_byte(FIXED_START_RESET);
      repeat (3) send_byte(END_CODE_RESET);
      send_byte(8'hff);
      // bytes outside any frame
      send_byte(8'h00);
      send_byte(8'hff);
      // variable frame of length one with a bad end
      send_byte(VAR_START_RESET);
      send_byte(8'h01);
      send_byte(8'h01);
      send_byte(VAR_START_RESET);
      send_byte(8'hc0);
      send_byte(8'hff);
      send_byte(8'h17);
   endtask

   // result side: random stall before each transfer, then check it
   task automatic collect_results();
      int      stall;
      rsp_type got;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.frame_byte = rsp_bus.frame_byte;
         got.in_frame = rsp_bus.in_frame;
         got.frame_position = rsp_bus.frame_position;
         got.variable_kind = rsp_bus.variable_kind;
         got.frame_last = rsp_bus.frame_last;
         got.frame_good = rsp_bus.frame_good;
         got.frame_total_length = rsp_bus.frame_total_length;
         tracker.check_result(got);
      end
   endtask

   // main sequence
   initial begin
      tracker = new();
      bytes_sent = 0;
      code_settings = 1;
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      rsp_bus.ready <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.addr <= CSR_FIXED_START;
      csr_bus.wdata <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none

      directed_frames();
      random_traffic(PHASE_BYTES);
      wait_idle();

      // extremes, equal start codes, then random and back to defaults
      program_codes(8'h00, 8'hff, 8'hff);
      random_traffic(PHASE_BYTES);
      wait_idle();
      program_codes(8'h5a, 8'h5a, 8'h00);
      random_traffic(PHASE_BYTES);
      wait_idle();
      program_codes(8'hff, 8'h00, 8'h80);
      random_traffic(PHASE_BYTES);
      wait_idle();
      program_codes(8'($urandom), 8'($urandom), 8'($urandom));
      random_traffic(PHASE_BYTES);
      wait_idle();
      program_codes(FIXED_START_RESET, VAR_START_RESET, END_CODE_RESET);
      random_traffic(PHASE_BYTES);
      wait_idle();
      repeat (8) @(posedge clock);

      $display("checked %0d tagged bytes of %0d sent under %0d code settings",
               tracker.checked, bytes_sent, code_settings);
      $display("frames closed: %0d good, %0d bad; longest variable length %0d",
               tracker.good_frames, tracker.bad_frames, tracker.longest);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
